// ----- src/zctf_pkg.sv -----
// Package for the zero-crossing triac fire controller.
// Holds widths, reset values, event codes, controller states and the
// command and status structs shared by the controller and the datapath.
package zctf_pkg;

    localparam int TIME_WIDTH     = 64;
    localparam int COUNT_WIDTH    = 32;
    localparam int EDGE_OUT_WIDTH = 32;
    localparam int LEN_WIDTH      = 27;
    localparam int MS_WIDTH       = 16;
    localparam int DEB_WIDTH      = 16;
    localparam int DUTY_WIDTH     = 8;
    localparam int HALF_WIDTH     = 16;
    localparam int WARM_CNT_WIDTH = 4;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;

    localparam int PROD_WIDTH = DUTY_WIDTH + LEN_WIDTH;
    localparam int WARM_WIDTH = WARM_CNT_WIDTH + HALF_WIDTH;
    localparam int MSK_WIDTH  = 26;
    localparam int MUL_WIDTH  = LEN_WIDTH + HALF_WIDTH;
    localparam int DIV_STEPS  = LEN_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

    localparam logic [MSK_WIDTH-1:0] MS_TO_US = MSK_WIDTH'(1000);
    localparam logic [LEN_WIDTH-1:0] LEN_MAX  = '1;

    localparam logic [DEB_WIDTH-1:0]      DEBOUNCE_RESET = DEB_WIDTH'(5000);
    localparam logic [DUTY_WIDTH-1:0]     DUTY_RESET     = DUTY_WIDTH'(30);
    localparam logic [HALF_WIDTH-1:0]     HALF_RESET     = HALF_WIDTH'(20000);
    localparam logic [WARM_CNT_WIDTH-1:0] WARMUP_RESET   = WARM_CNT_WIDTH'(6);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DUTY     = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HALF     = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WARMUP   = 2'd3;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_POS     = 3'd1,
        CMD_NEG     = 3'd2,
        CMD_ARM     = 3'd3,
        CMD_DISARM  = 3'd4,
        CMD_WARMUP  = 3'd5,
        CMD_FIRE    = 3'd6,
        CMD_FIRE_NW = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_EVAL,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic eval;
        logic div_step;
        logic mul;
        logic out_load;
        cmd_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_ok;
        logic half_zero;
        logic div_last;
    } dp_status_t;

endpackage

// ----- src/zctf_ctrl.sv -----
// Controller of the zero-crossing triac fire controller.
// Sequences each item through its phases and owns the result handshake.
// Depends on zctf_pkg.
module zctf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output zctf_pkg::ctrl_cmd_t  dp_cmd,
    input  zctf_pkg::dp_status_t dp_status
);
    import zctf_pkg::*;

    state_t state_reg, state_next;
    cmd_t   op_reg;
    logic   m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= CMD_TICK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (dp_cmd.load) begin
                op_reg <= cmd_t'(s_cmd);
            end
            if (dp_cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        dp_cmd.op  = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dp_cmd.load = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC: begin
                dp_cmd.calc = 1'b1;
                state_next  = ST_EVAL;
            end
            ST_EVAL: begin
                dp_cmd.eval = 1'b1;
                if (op_reg == CMD_FIRE && dp_status.req_ok && !dp_status.half_zero) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                dp_cmd.div_step = 1'b1;
                if (dp_status.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                dp_cmd.mul = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("a second item was taken while one is in work");
    a_div_only_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (op_reg == CMD_FIRE))
        else $error("division entered for an item that is not a rounded fire");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule

// ----- src/zctf_datapath.sv -----
// Datapath of the zero-crossing triac fire controller.
// Holds configuration, time and fire state, the restoring divider and the
// result registers. Depends on zctf_pkg.
module zctf_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [zctf_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [zctf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic [zctf_pkg::MS_WIDTH-1:0]         s_fire_ms,
    input  zctf_pkg::ctrl_cmd_t                   dp_cmd,
    output zctf_pkg::dp_status_t                  dp_status,
    output logic                                  m_accepted,
    output logic                                  m_fire_drive,
    output logic                                  m_arm_drive,
    output logic                                  m_fire_pending,
    output logic [zctf_pkg::EDGE_OUT_WIDTH-1:0]   m_pos_edges,
    output logic [zctf_pkg::EDGE_OUT_WIDTH-1:0]   m_neg_edges,
    output logic [zctf_pkg::LEN_WIDTH-1:0]        m_last_fire_us
);
    import zctf_pkg::*;

    logic [DEB_WIDTH-1:0]      debounce_reg;
    logic [DUTY_WIDTH-1:0]     duty_reg;
    logic [HALF_WIDTH-1:0]     half_reg;
    logic [WARM_CNT_WIDTH-1:0] warmup_reg;

    logic [TIME_WIDTH-1:0]  now_reg;
    logic [TIME_WIDTH-1:0]  last_pos_reg;
    logic [TIME_WIDTH-1:0]  last_neg_reg;
    logic [TIME_WIDTH-1:0]  fire_start_reg;
    logic [TIME_WIDTH-1:0]  fire_end_reg;
    logic [COUNT_WIDTH-1:0] pos_cnt_reg;
    logic [COUNT_WIDTH-1:0] neg_cnt_reg;
    logic [LEN_WIDTH-1:0]   fire_len_reg;
    logic [LEN_WIDTH-1:0]   actual_len_reg;
    logic                   pending_reg;
    logic                   firing_reg;
    logic                   armed_reg;

    logic [MS_WIDTH-1:0]      ms_reg;
    logic [TIME_WIDTH-1:0]    diff_reg;
    logic [PROD_WIDTH-1:0]    prod_reg;
    logic [WARM_WIDTH-1:0]    warm_reg;
    logic [MSK_WIDTH-1:0]     msk_reg;
    logic [LEN_WIDTH-1:0]     quot_reg;
    logic [HALF_WIDTH-1:0]    rem_reg;
    logic [DIV_CNT_WIDTH-1:0] div_cnt_reg;
    logic                     acc_reg;

    logic [TIME_WIDTH-1:0] elapsed;
    logic [LEN_WIDTH-1:0]  elapsed_sat;
    logic                  stop_fire;
    logic                  edge_ok;
    logic                  cooled;
    logic                  req_ok;
    logic [LEN_WIDTH-1:0]  len_sum;
    logic [HALF_WIDTH:0]   trial;
    logic                  trial_ge;
    logic [MUL_WIDTH-1:0]  mul_full;
    logic                  div_start;

    assign elapsed     = now_reg - fire_start_reg;
    assign elapsed_sat = (elapsed > TIME_WIDTH'(LEN_MAX)) ? LEN_MAX
                                                          : elapsed[LEN_WIDTH-1:0];
    assign stop_fire   = firing_reg && (elapsed >= TIME_WIDTH'(fire_len_reg));
    assign edge_ok     = diff_reg > TIME_WIDTH'(debounce_reg);
    assign cooled      = (actual_len_reg == '0) || (diff_reg >= TIME_WIDTH'(prod_reg));
    assign req_ok      = cooled && armed_reg;
    assign len_sum     = LEN_WIDTH'(msk_reg) + LEN_WIDTH'(warm_reg);
    assign trial       = {rem_reg, quot_reg[LEN_WIDTH-1]};
    assign trial_ge    = trial >= (HALF_WIDTH + 1)'(half_reg);
    assign mul_full    = MUL_WIDTH'(quot_reg) * MUL_WIDTH'(half_reg);
    assign div_start   = dp_cmd.eval && dp_cmd.op == CMD_FIRE && req_ok && half_reg != '0;

    assign dp_status.req_ok    = req_ok;
    assign dp_status.half_zero = (half_reg == '0);
    assign dp_status.div_last  = (div_cnt_reg == DIV_CNT_WIDTH'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            duty_reg       <= DUTY_RESET;
            half_reg       <= HALF_RESET;
            warmup_reg     <= WARMUP_RESET;
            now_reg        <= '0;
            last_pos_reg   <= '0;
            last_neg_reg   <= '0;
            fire_start_reg <= '0;
            fire_end_reg   <= '0;
            pos_cnt_reg    <= '0;
            neg_cnt_reg    <= '0;
            fire_len_reg   <= '0;
            actual_len_reg <= '0;
            pending_reg    <= 1'b0;
            firing_reg     <= 1'b0;
            armed_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_DEBOUNCE: debounce_reg <= cfg_data[DEB_WIDTH-1:0];
                    CFG_DUTY:     duty_reg     <= cfg_data[DUTY_WIDTH-1:0];
                    CFG_HALF:     half_reg     <= cfg_data[HALF_WIDTH-1:0];
                    CFG_WARMUP:   warmup_reg   <= cfg_data[WARM_CNT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (dp_cmd.calc && dp_cmd.op == CMD_TICK) begin
                now_reg <= now_reg + TIME_WIDTH'(1);
            end
            if (dp_cmd.eval) begin
                case (dp_cmd.op)
                    CMD_TICK: begin
                        if (stop_fire) begin
                            firing_reg     <= 1'b0;
                            actual_len_reg <= elapsed_sat;
                        end
                    end
                    CMD_POS: begin
                        if (edge_ok) begin
                            pos_cnt_reg  <= pos_cnt_reg + COUNT_WIDTH'(1);
                            last_pos_reg <= now_reg;
                            if (pending_reg) begin
                                fire_start_reg <= now_reg;
                                fire_end_reg   <= now_reg + TIME_WIDTH'(fire_len_reg);
                                pending_reg    <= 1'b0;
                                actual_len_reg <= '0;
                                firing_reg     <= 1'b1;
                            end
                        end
                    end
                    CMD_NEG: begin
                        if (edge_ok) begin
                            neg_cnt_reg  <= neg_cnt_reg + COUNT_WIDTH'(1);
                            last_neg_reg <= now_reg;
                        end
                    end
                    CMD_ARM:    armed_reg <= 1'b1;
                    CMD_DISARM: armed_reg <= 1'b0;
                    CMD_WARMUP: begin
                        if (req_ok) begin
                            pending_reg  <= 1'b1;
                            fire_len_reg <= LEN_WIDTH'(warm_reg);
                        end
                    end
                    CMD_FIRE: begin
                        if (req_ok) begin
                            pending_reg <= 1'b1;
                            if (half_reg == '0) begin
                                fire_len_reg <= len_sum;
                            end
                        end
                    end
                    default: begin
                        if (req_ok) begin
                            pending_reg  <= 1'b1;
                            fire_len_reg <= LEN_WIDTH'(msk_reg);
                        end
                    end
                endcase
            end
            if (dp_cmd.mul) begin
                fire_len_reg <= mul_full[LEN_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            ms_reg  <= s_fire_ms;
            acc_reg <= 1'b0;
        end
        if (dp_cmd.calc) begin
            case (dp_cmd.op)
                CMD_POS: diff_reg <= now_reg - last_pos_reg;
                CMD_NEG: diff_reg <= now_reg - last_neg_reg;
                default: diff_reg <= now_reg - fire_end_reg;
            endcase
            prod_reg <= PROD_WIDTH'(duty_reg) * PROD_WIDTH'(actual_len_reg);
            warm_reg <= WARM_WIDTH'(warmup_reg) * WARM_WIDTH'(half_reg);
            msk_reg  <= MSK_WIDTH'(ms_reg) * MS_TO_US;
        end
        if (dp_cmd.eval) begin
            case (dp_cmd.op) inside
                CMD_ARM, CMD_DISARM: acc_reg <= 1'b1;
                CMD_WARMUP, CMD_FIRE, CMD_FIRE_NW: acc_reg <= req_ok;
                default: acc_reg <= 1'b0;
            endcase
        end
        if (div_start) begin
            quot_reg    <= len_sum;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (dp_cmd.div_step) begin
            rem_reg     <= trial_ge ? HALF_WIDTH'(trial - (HALF_WIDTH + 1)'(half_reg))
                                    : trial[HALF_WIDTH-1:0];
            quot_reg    <= {quot_reg[LEN_WIDTH-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_WIDTH'(1);
        end
        if (dp_cmd.out_load) begin
            m_accepted     <= acc_reg;
            m_fire_drive   <= firing_reg;
            m_arm_drive    <= armed_reg;
            m_fire_pending <= pending_reg;
            m_pos_edges    <= EDGE_OUT_WIDTH'(pos_cnt_reg);
            m_neg_edges    <= EDGE_OUT_WIDTH'(neg_cnt_reg);
            m_last_fire_us <= actual_len_reg;
        end
    end

endmodule

// ----- src/zero_cross_triac_fire_controller.sv -----
// Zero-crossing triac fire controller: one result item per event item.
// Each accepted item runs the calc, eval and out steps; out registers the
// result once the output register is free; an accepted rounded timed fire also
// runs the one-bit-per-cycle restoring divider and a multiply step. The next
// item is taken after the result is loaded. Reset (aresetn low, synchronous)
// clears all time, count and fire state and loads the default configuration.
module zero_cross_triac_fire_controller (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [zctf_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [zctf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_cmd,
    input  logic [zctf_pkg::MS_WIDTH-1:0]         s_fire_ms,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_accepted,
    output logic                                  m_fire_drive,
    output logic                                  m_arm_drive,
    output logic                                  m_fire_pending,
    output logic [zctf_pkg::EDGE_OUT_WIDTH-1:0]   m_pos_edges,
    output logic [zctf_pkg::EDGE_OUT_WIDTH-1:0]   m_neg_edges,
    output logic [zctf_pkg::LEN_WIDTH-1:0]        m_last_fire_us
);
    import zctf_pkg::*;

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    zctf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    zctf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_fire_ms      (s_fire_ms),
        .dp_cmd         (dp_cmd),
        .dp_status      (dp_status),
        .m_accepted     (m_accepted),
        .m_fire_drive   (m_fire_drive),
        .m_arm_drive    (m_arm_drive),
        .m_fire_pending (m_fire_pending),
        .m_pos_edges    (m_pos_edges),
        .m_neg_edges    (m_neg_edges),
        .m_last_fire_us (m_last_fire_us)
    );

endmodule

// ----- dv/tb_zero_cross_triac_fire_controller.sv -----
// Self-checking testbench for the zero-cross triac fire controller.
// Drives event items and register writes, predicts every status item in-line
// and compares it field by field. Depends on zctf_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_zero_cross_triac_fire_controller;
    import zctf_pkg::*;

    localparam int US_PER_MS = 1000;

    typedef struct packed {
        cmd_t                  cmd;
        logic [MS_WIDTH-1:0]   ms;
    } event_item_t;

    typedef struct packed {
        logic                      accepted;
        logic                      fire_drive;
        logic                      arm_drive;
        logic                      fire_pending;
        logic [EDGE_OUT_WIDTH-1:0] pos_edges;
        logic [EDGE_OUT_WIDTH-1:0] neg_edges;
        logic [LEN_WIDTH-1:0]      last_fire_us;
    } status_t;

    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]    cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [2:0]                  s_cmd = CMD_TICK;
    logic [MS_WIDTH-1:0]         s_fire_ms = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_accepted;
    logic                        m_fire_drive;
    logic                        m_arm_drive;
    logic                        m_fire_pending;
    logic [EDGE_OUT_WIDTH-1:0]   m_pos_edges;
    logic [EDGE_OUT_WIDTH-1:0]   m_neg_edges;
    logic [LEN_WIDTH-1:0]        m_last_fire_us;

    zero_cross_triac_fire_controller u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_fire_ms      (s_fire_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_fire_drive   (m_fire_drive),
        .m_arm_drive    (m_arm_drive),
        .m_fire_pending (m_fire_pending),
        .m_pos_edges    (m_pos_edges),
        .m_neg_edges    (m_neg_edges),
        .m_last_fire_us (m_last_fire_us)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Controller image kept by the testbench.
    logic [DEB_WIDTH-1:0]      deb_limit;
    logic [DUTY_WIDTH-1:0]     duty_mult;
    logic [HALF_WIDTH-1:0]     half_len;
    logic [WARM_CNT_WIDTH-1:0] warm_count;

    logic [TIME_WIDTH-1:0]     clock_us;
    logic [TIME_WIDTH-1:0]     pos_stamp;
    logic [TIME_WIDTH-1:0]     neg_stamp;
    logic [COUNT_WIDTH-1:0]    pos_total;
    logic [COUNT_WIDTH-1:0]    neg_total;
    logic [TIME_WIDTH-1:0]     burst_start;
    logic [TIME_WIDTH-1:0]     burst_end;
    logic [LEN_WIDTH-1:0]      burst_len;
    logic [LEN_WIDTH-1:0]      measured_len;
    logic                      burst_waiting;
    logic                      burst_on;
    logic                      armed;

    event_item_t pending_events[$];
    status_t     expected_status[$];

    int items_queued = 0;
    int items_taken = 0;
    int errors = 0;
    int requests_taken = 0;
    int requests_refused = 0;
    int fires_started = 0;
    int fires_ended = 0;
    int settings_used = 0;

    int  send_idle_pct = 25;
    int  recv_idle_pct = 52;
    logic rx_stall = 1'b0;
    logic stall_go = 1'b0;

    task automatic reset_image();
        deb_limit     = DEBOUNCE_RESET;
        duty_mult     = DUTY_RESET;
        half_len      = HALF_RESET;
        warm_count    = WARMUP_RESET;
        clock_us      = '0;
        pos_stamp     = '0;
        neg_stamp     = '0;
        pos_total     = '0;
        neg_total     = '0;
        burst_start   = '0;
        burst_end     = '0;
        burst_len     = '0;
        measured_len  = '0;
        burst_waiting = 1'b0;
        burst_on      = 1'b0;
        armed         = 1'b0;
    endtask

    function automatic logic try_request(logic [TIME_WIDTH-1:0] len);
        logic [TIME_WIDTH-1:0] cool;
        logic                  cooled;
        cool = clock_us - burst_end;
        cooled = (measured_len == '0) ||
                 (cool >= TIME_WIDTH'(duty_mult) * TIME_WIDTH'(measured_len));
        if (!(cooled && armed)) begin
            requests_refused++;
            return 1'b0;
        end
        burst_len = len[LEN_WIDTH-1:0];
        burst_waiting = 1'b1;
        requests_taken++;
        return 1'b1;
    endfunction

    function automatic status_t apply_event(cmd_t op, logic [MS_WIDTH-1:0] ms);
        logic [TIME_WIDTH-1:0] warm;
        logic [TIME_WIDTH-1:0] len;
        logic [TIME_WIDTH-1:0] elapsed;
        logic                  ok;
        status_t               r;
        ok = 1'b0;
        warm = TIME_WIDTH'(warm_count) * TIME_WIDTH'(half_len);
        case (op)
            CMD_TICK: begin
                clock_us = clock_us + 1'b1;
                if (burst_on) begin
                    elapsed = clock_us - burst_start;
                    if (elapsed >= TIME_WIDTH'(burst_len)) begin
                        burst_on = 1'b0;
                        measured_len = (elapsed > TIME_WIDTH'(LEN_MAX)) ?
                                       LEN_MAX : elapsed[LEN_WIDTH-1:0];
                        fires_ended++;
                    end
                end
            end
            CMD_POS: begin
                if (clock_us - pos_stamp > TIME_WIDTH'(deb_limit)) begin
                    pos_total = pos_total + 1'b1;
                    pos_stamp = clock_us;
                    if (burst_waiting) begin
                        burst_start = clock_us;
                        burst_end = clock_us + TIME_WIDTH'(burst_len);
                        burst_waiting = 1'b0;
                        measured_len = '0;
                        burst_on = 1'b1;
                        fires_started++;
                    end
                end
            end
            CMD_NEG: begin
                if (clock_us - neg_stamp > TIME_WIDTH'(deb_limit)) begin
                    neg_total = neg_total + 1'b1;
                    neg_stamp = clock_us;
                end
            end
            CMD_ARM: begin
                armed = 1'b1;
                ok = 1'b1;
            end
            CMD_DISARM: begin
                armed = 1'b0;
                ok = 1'b1;
            end
            CMD_WARMUP: ok = try_request(warm);
            CMD_FIRE: begin
                len = TIME_WIDTH'(ms) * TIME_WIDTH'(US_PER_MS) + warm;
                if (half_len != '0)
                    len = (len / TIME_WIDTH'(half_len)) * TIME_WIDTH'(half_len);
                ok = try_request(len);
            end
            default: ok = try_request(TIME_WIDTH'(ms) * TIME_WIDTH'(US_PER_MS));
        endcase
        r.accepted     = ok;
        r.fire_drive   = burst_on;
        r.arm_drive    = armed;
        r.fire_pending = burst_waiting;
        r.pos_edges    = EDGE_OUT_WIDTH'(pos_total);
        r.neg_edges    = EDGE_OUT_WIDTH'(neg_total);
        r.last_fire_us = measured_len;
        return r;
    endfunction

    always @(posedge aclk) begin : event_driver
        event_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_status.push_back(apply_event(cmd_t'(s_cmd), s_fire_ms));
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_events.pop_front();
                    s_valid   <= 1'b1;
                    s_cmd     <= nxt.cmd;
                    s_fire_ms <= nxt.ms;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 100)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : status_monitor
        status_t got;
        status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_accepted, m_fire_drive, m_arm_drive, m_fire_pending,
                       m_pos_edges, m_neg_edges, m_last_fire_us};
                if (expected_status.size() == 0) begin
                    errors++;
                    $display("%0t: status item with no expectation, expected none, actual %0h",
                             $time, got);
                end else begin
                    want = expected_status.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("fire_drive", 32'(want.fire_drive), 32'(got.fire_drive));
                    check_field("arm_drive", 32'(want.arm_drive), 32'(got.arm_drive));
                    check_field("fire_pending", 32'(want.fire_pending),
                                32'(got.fire_pending));
                    check_field("pos_edges", want.pos_edges, got.pos_edges);
                    check_field("neg_edges", want.neg_edges, got.neg_edges);
                    check_field("last_fire_us", 32'(want.last_fire_us),
                                32'(got.last_fire_us));
                end
            end
            m_ready <= rx_stall ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off so the controller backs up into its input.
    initial begin
        wait (stall_go);
        @(posedge aclk);
        rx_stall <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_stall <= 1'b0;
    end

    task automatic push_event(cmd_t c, logic [MS_WIDTH-1:0] ms);
        event_item_t it;
        it.cmd = c;
        it.ms = ms;
        pending_events.push_back(it);
        items_queued++;
    endtask

    function automatic logic [MS_WIDTH-1:0] pick_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82)
            return '0;
        if (r < 90)
            return MS_WIDTH'(1);
        return MS_WIDTH'($urandom_range(0, 65535));
    endfunction

    task automatic push_ticks(int n);
        repeat (n) push_event(CMD_TICK, MS_WIDTH'($urandom_range(0, 65535)));
    endtask

    task automatic push_random(int n);
        int target;
        target = items_queued + n;
        while (items_queued < target) begin
            if ($urandom_range(0, 99) < 65) begin
                if ($urandom_range(0, 1) == 1)
                    push_event(CMD_ARM, pick_ms());
                push_event(cmd_t'($urandom_range(CMD_WARMUP, CMD_FIRE_NW)), pick_ms());
                push_ticks($urandom_range(0, 4));
                push_event(CMD_POS, pick_ms());
                push_ticks($urandom_range(0, 12));
                if ($urandom_range(0, 99) < 40)
                    push_event(CMD_NEG, pick_ms());
                push_ticks($urandom_range(0, 20));
                if ($urandom_range(0, 99) < 8)
                    push_event(CMD_DISARM, pick_ms());
            end else begin
                push_event(cmd_t'($urandom_range(CMD_TICK, CMD_FIRE_NW)), pick_ms());
            end
        end
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (items_taken != items_queued || expected_status.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: deb_limit  = data[DEB_WIDTH-1:0];
            CFG_DUTY:     duty_mult  = data[DUTY_WIDTH-1:0];
            CFG_HALF:     half_len   = data[HALF_WIDTH-1:0];
            default:      warm_count = data[WARM_CNT_WIDTH-1:0];
        endcase
    endtask

    task automatic set_config(logic [15:0] deb, logic [15:0] duty,
                              logic [15:0] half, logic [15:0] warm);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_DUTY, duty);
        write_reg(CFG_HALF, half);
        write_reg(CFG_WARMUP, warm);
        settings_used++;
    endtask

    initial begin
        reset_image();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default settings: requests are refused until armed, edges fall in lockout.
        push_event(CMD_WARMUP, '0);
        push_event(CMD_POS, '0);
        push_event(CMD_NEG, '1);
        push_event(CMD_TICK, '1);
        push_event(CMD_ARM, '0);
        push_event(CMD_FIRE, '1);
        push_event(CMD_FIRE_NW, '0);
        push_event(CMD_WARMUP, '1);
        push_event(CMD_DISARM, '1);
        push_event(CMD_FIRE, '0);
        push_event(CMD_POS, '0);
        drain();

        // No lockout, no cooling and no rounding: zero-length fires,
        // disarm during a fire, and a request while firing.
        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        push_event(CMD_ARM, '0);
        push_event(CMD_FIRE_NW, '0);
        push_event(CMD_TICK, '0);
        push_event(CMD_POS, '0);
        push_event(CMD_POS, '0);
        push_event(CMD_DISARM, '0);
        push_event(CMD_TICK, '0);
        push_event(CMD_WARMUP, '0);
        push_event(CMD_ARM, '0);
        push_event(CMD_FIRE, '0);
        push_event(CMD_TICK, '0);
        push_event(CMD_POS, '0);
        push_event(CMD_FIRE_NW, '0);
        push_event(CMD_TICK, '0);
        drain();

        set_config(16'd3, 16'd2, 16'd4, 16'd2);
        push_random(200);
        drain();
        push_random(200);
        drain();

        send_idle_pct = 52;
        recv_idle_pct = 25;
        set_config(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
        push_random(250);
        drain();
        set_config(16'hFFFF, 16'd1, 16'd0, 16'd0);
        push_random(120);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(16'd2, 16'd0, 16'hFFFF, 16'd0);
        push_random(300);
        stall_go = 1'b1;
        drain();
        set_config(16'd1, 16'd3, 16'd3, 16'd1);
        push_random(180);
        drain();

        repeat (40) @(posedge aclk);
        $display("Ran %0d event items over %0d register settings plus defaults.",
                 items_taken, settings_used);
        $display("Requests taken %0d, refused %0d; fires started %0d, ended %0d.",
                 requests_taken, requests_refused, fires_started, fires_ended);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/zctf_pkg.sv
src/zctf_ctrl.sv
src/zctf_datapath.sv
src/zero_cross_triac_fire_controller.sv
dv/tb_zero_cross_triac_fire_controller.sv
